### sv/lesf_pkg.sv
// Shared types and constants for the largest empty square finder.
// No dependencies; every other file of the block depends on this package.
package lesf_pkg;

	localparam int SIZE_W = 11;
	localparam int POS_W  = 10;
	localparam int CNT_W  = 11;

	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CNT_W-1:0]  count_t;

	// Register indexes on the configuration port (decoded from paddr[2])
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	// Clamped grid dimensions plus a one-cycle restart strobe from the config block
	typedef struct packed {
		count_t rows;
		count_t cols;
		logic   restart;
	} cfg_t;

endpackage

### sv/lesf_if.sv
// Valid/ready channel interfaces for grid cells in and square results out.
// Depends on lesf_pkg for the payload types.
interface lesf_cell_if;
	logic valid;
	logic ready;
	logic is_empty;

	modport source (output valid, output is_empty, input ready);
	modport sink   (input valid, input is_empty, output ready);
endinterface

interface lesf_result_if;
	logic           valid;
	logic           ready;
	lesf_pkg::size_t square_size;
	lesf_pkg::pos_t  top_row;
	lesf_pkg::pos_t  left_col;

	modport source (output valid, output square_size, output top_row, output left_col,
		input ready);
	modport sink   (input valid, input square_size, input top_row, input left_col,
		output ready);
endinterface

### sv/lesf_cfg.sv
// APB-style register block holding row_count and col_count.
// Depends on lesf_pkg; clamps the counts to the grid bounds for the datapath.
module lesf_cfg #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output lesf_pkg::cfg_t     cfg
);
	import lesf_pkg::*;

	localparam int ROW_LIM = (MAX_ROWS > 2047) ? 2047 : MAX_ROWS;
	localparam int COL_LIM = (MAX_COLS > 2047) ? 2047 : MAX_COLS;
	localparam count_t ROW_BOUND = CNT_W'(ROW_LIM);
	localparam count_t COL_BOUND = CNT_W'(COL_LIM);

	count_t row_count_q;
	count_t col_count_q;
	logic   wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= count_t'(1);
			col_count_q <= count_t'(1);
		end else begin
			if (wr) begin
				unique case (paddr[2])
					REG_ROW_COUNT: row_count_q <= pwdata[CNT_W-1:0];
					REG_COL_COUNT: col_count_q <= pwdata[CNT_W-1:0];
				endcase
			end
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROW_COUNT: prdata = {{(32-CNT_W){1'b0}}, row_count_q};
			REG_COL_COUNT: prdata = {{(32-CNT_W){1'b0}}, col_count_q};
		endcase
	end

	// Zero becomes one for the datapath, anything above the bound saturates
	always_comb begin
		if (row_count_q == '0)
			cfg.rows = count_t'(1);
		else if (row_count_q > ROW_BOUND)
			cfg.rows = ROW_BOUND;
		else
			cfg.rows = row_count_q;

		if (col_count_q == '0)
			cfg.cols = count_t'(1);
		else if (col_count_q > COL_BOUND)
			cfg.cols = COL_BOUND;
		else
			cfg.cols = col_count_q;

		cfg.restart = wr;
	end

endmodule

### sv/lesf_line_mem.sv
// Line buffer of square sizes from the previous row: one write, one registered read port.
// Depends on lesf_pkg for the entry type.
module lesf_line_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  lesf_pkg::size_t     wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output lesf_pkg::size_t     rdata
);
	import lesf_pkg::*;

	size_t mem [DEPTH];
	size_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/largest_empty_square_finder.sv
// Largest empty square finder: takes one grid cell per clock in row-major order and, once
// the last cell of a row_count x col_count grid has passed through stage 1,
// registers the side and the top-left corner of the largest all-empty square (first in
// row-major order on a tie, size 0 if none). The rate of one cell per cycle is set by the one
// read and the one write of the line buffer each cycle, which holds one size per column; a
// same-column write and read in one cycle is forwarded. The input stalls only while the last
// cell of a grid waits behind an untaken result. Writing either count register restarts the
// scan; no clearing pass follows reset, as the first row of a grid ignores the read data.
module largest_empty_square_finder #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lesf_cell_if.sink            cells,
	lesf_result_if.source        result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import lesf_pkg::*;

	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW = ((RW > CNT_W) ? RW : CNT_W) + 1;
	localparam int CCW = ((CW > CNT_W) ? CW : CNT_W) + 1;

	cfg_t cfg;

	lesf_cfg #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Scan position of the next cell
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          last_col;
	logic          last_row;

	// Stage 1: cell whose line-buffer read is in flight
	logic          valid_s1;
	logic          empty_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;
	logic          row0_s1;
	logic          last_s1;
	logic          fwd_s1;
	size_t         fwd_data_s1;

	size_t left_q;
	size_t diag_q;
	size_t best_size_q;
	pos_t  best_row_q;
	pos_t  best_col_q;

	logic  res_valid_q;
	size_t res_size_q;
	pos_t  res_row_q;
	pos_t  res_col_q;

	logic  accept;
	logic  advance;
	logic  mem_we;
	size_t rdata;
	size_t up;
	size_t left;
	size_t diag;
	size_t m;
	size_t size;
	logic  better;
	pos_t  cand_row;
	pos_t  cand_col;
	size_t nbest_size;
	pos_t  nbest_row;
	pos_t  nbest_col;

	// Hold stage 1 only when it would overwrite an untaken result
	assign advance     = !valid_s1 || !(last_s1 && res_valid_q && !result.ready);
	assign cells.ready = advance;
	assign accept      = cells.valid && cells.ready;
	assign mem_we      = valid_s1 && advance;

	assign last_col = (CCW'(col_q) + CCW'(1)) >= CCW'(cfg.cols);
	assign last_row = (RCW'(row_q) + RCW'(1)) >= RCW'(cfg.rows);

	lesf_line_mem #(.DEPTH(MAX_COLS), .AW(CW)) u_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (col_s1),
		.wdata (size),
		.re    (accept),
		.raddr (col_q),
		.rdata (rdata)
	);

	always_comb begin
		left = (col_s1 == '0) ? '0 : left_q;
		diag = (col_s1 == '0) ? '0 : diag_q;
		if (row0_s1)
			up = '0;
		else if (fwd_s1)
			up = fwd_data_s1;
		else
			up = rdata;

		m = (left < up) ? left : up;
		m = (m < diag) ? m : diag;
		size = empty_s1 ? (m + size_t'(1)) : '0;

		better   = size > best_size_q;
		cand_row = POS_W'(RCW'(row_s1) + RCW'(1) - RCW'(size));
		cand_col = POS_W'(CCW'(col_s1) + CCW'(1) - CCW'(size));

		nbest_size = better ? size     : best_size_q;
		nbest_row  = better ? cand_row : best_row_q;
		nbest_col  = better ? cand_col : best_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (cfg.restart) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance)
				valid_s1 <= accept;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			empty_s1    <= cells.is_empty;
			row_s1      <= row_q;
			col_s1      <= col_q;
			row0_s1     <= (row_q == '0);
			last_s1     <= last_col && last_row;
			fwd_s1      <= mem_we && (col_s1 == col_q);
			fwd_data_s1 <= size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (result.ready)
				res_valid_q <= 1'b0;
			if (cfg.restart) begin
				left_q      <= '0;
				diag_q      <= '0;
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else if (mem_we) begin
				left_q <= size;
				diag_q <= up;
				if (last_s1) begin
					res_valid_q <= 1'b1;
					best_size_q <= '0;
					best_row_q  <= '0;
					best_col_q  <= '0;
				end else begin
					best_size_q <= nbest_size;
					best_row_q  <= nbest_row;
					best_col_q  <= nbest_col;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && last_s1) begin
			res_size_q <= nbest_size;
			res_row_q  <= nbest_row;
			res_col_q  <= nbest_col;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.square_size = res_size_q;
	assign result.top_row     = res_row_q;
	assign result.left_col    = res_col_q;

endmodule

### test/tb_top.sv
// Self-checking testbench for largest_empty_square_finder: streams grid cells, predicts
// each square result in step with the accepted cells and compares it on the result channel.
// Depends on lesf_pkg and the channel interfaces in lesf_if.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lesf_pkg::*;

	localparam int unsigned ROW_LIMIT = 1024;
	localparam int unsigned COL_LIMIT = 1024;
	localparam int SETTLE = 8;

	typedef struct packed {
		size_t square_size;
		pos_t  top_row;
		pos_t  left_col;
	} square_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lesf_cell_if   cell_ch();
	lesf_result_if result_ch();

	largest_empty_square_finder #(
		.MAX_ROWS(ROW_LIMIT),
		.MAX_COLS(COL_LIMIT)
	) DUT (clk, arst_n, cell_ch, result_ch, psel, penable, pwrite, paddr, pwdata, prdata,
		pready);

	// Predictor state: count registers, line of sizes from the row above, scan position
	count_t      rows_reg;
	count_t      cols_reg;
	int unsigned line_sizes [COL_LIMIT];
	int unsigned left_sz;
	int unsigned diag_sz;
	int unsigned row_at;
	int unsigned col_at;
	int unsigned best_sz;
	int unsigned best_r;
	int unsigned best_c;

	square_t     pending_squares [$];
	int unsigned errors;
	int unsigned items_sent;
	bit          no_idle;

	always #5 clk = ~clk;

	function automatic int unsigned clamp_dim(count_t v, int unsigned bound);
		if (v == '0)
			return 1;
		if (v > bound)
			return bound;
		return v;
	endfunction

	function automatic void clear_scan();
		left_sz = 0;
		diag_sz = 0;
		row_at  = 0;
		col_at  = 0;
		best_sz = 0;
		best_r  = 0;
		best_c  = 0;
	endfunction

	function automatic void set_count(logic idx, count_t val);
		if (idx == REG_ROW_COUNT)
			rows_reg = val;
		else
			cols_reg = val;
		clear_scan();
	endfunction

	// Grow the square ending at this cell and emit the best one after the last cell
	function automatic void track_cell(logic empty_cell);
		int unsigned rows;
		int unsigned cols;
		int unsigned col;
		int unsigned up;
		int unsigned sz;
		square_t     sq;
		rows = clamp_dim(rows_reg, ROW_LIMIT);
		cols = clamp_dim(cols_reg, COL_LIMIT);
		col  = (col_at >= cols) ? cols - 1 : col_at;
		if (col == 0) begin
			left_sz = 0;
			diag_sz = 0;
		end
		up = (row_at == 0) ? 0 : line_sizes[col];
		sz = 0;
		if (empty_cell) begin
			sz = left_sz;
			if (up < sz)
				sz = up;
			if (diag_sz < sz)
				sz = diag_sz;
			sz = sz + 1;
		end
		diag_sz = up;
		left_sz = sz;
		line_sizes[col] = sz;
		if (sz > best_sz) begin
			best_sz = sz;
			best_r  = row_at + 1 - sz;
			best_c  = col + 1 - sz;
		end
		if (col + 1 >= cols) begin
			col_at = 0;
			if (row_at + 1 >= rows) begin
				sq.square_size = size_t'(best_sz);
				sq.top_row     = pos_t'(best_r);
				sq.left_col    = pos_t'(best_c);
				pending_squares.push_back(sq);
				clear_scan();
			end else begin
				row_at = row_at + 1;
			end
		end else begin
			col_at = col + 1;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction
	task automatic send_cell(input logic empty_cell);
		if (!no_idle && $urandom_range(0, 99) < 5) begin
			cell_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		cell_ch.valid    <= 1'b1;
		cell_ch.is_empty <= empty_cell;
		do @(posedge clk); while (!cell_ch.ready);
		track_cell(empty_cell);
		items_sent++;
		@(negedge clk);
	endtask

	// Cells listed row-major from the most significant bit down
	task automatic send_pattern(input logic [31:0] bits, input int n);
		for (int i = 0; i < n; i++)
			send_cell(bits[n - 1 - i]);
	endtask

	task automatic send_random_cells(input int n, input int pct);
		for (int i = 0; i < n; i++)
			send_cell($urandom_range(1, 100) <= pct);
	endtask

	task automatic drain_results();
		cell_ch.valid <= 1'b0;
		while (pending_squares.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input count_t val);
		logic [31:0] word;
		word    = ($urandom() & 32'hFFFF_F800) | 32'(val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		set_count(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_directed_grids();
		// reset leaves a 1 x 1 grid
		send_cell(1'b1);
		send_cell(1'b0);
		drain_results();
		write_reg(REG_ROW_COUNT, 11'd2);
		write_reg(REG_COL_COUNT, 11'd3);
		send_pattern(32'b000_000, 6);
		send_pattern(32'b111_111, 6);
		send_pattern(32'b101_101, 6);
		send_pattern(32'b000_001, 6);
		drain_results();
	endtask

	task automatic run_count_limits();
		no_idle = 1'b1;
		write_reg(REG_ROW_COUNT, 11'd0);
		write_reg(REG_COL_COUNT, 11'd0);
		send_cell(1'b1);
		send_cell(1'b1);
		drain_results();
		write_reg(REG_ROW_COUNT, 11'd1);
		write_reg(REG_COL_COUNT, 11'd2047);
		send_random_cells(1023, 0);
		send_cell(1'b1);
		drain_results();
		no_idle = 1'b0;
	endtask

	task automatic run_scan_restart();
		write_reg(REG_ROW_COUNT, 11'd4);
		write_reg(REG_COL_COUNT, 11'd5);
		send_random_cells(7, 80);
		drain_results();
		write_reg(REG_ROW_COUNT, 11'd4);
		send_random_cells(20, 80);
		send_random_cells(13, 90);
		drain_results();
		write_reg(REG_COL_COUNT, 11'd5);
		send_random_cells(20, 85);
		drain_results();
	endtask

	task automatic run_random_grids();
		int unsigned goal;
		int unsigned cells;
		count_t      r;
		count_t      c;
		int          grids;
		int          pct;
		bit          cut;
		goal = items_sent + 150;
		while (items_sent < goal) begin
			drain_results();
			r = count_t'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) :
				$urandom_range(1, 8));
			c = count_t'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) :
				$urandom_range(1, 8));
			if ($urandom_range(0, 19) == 0)
				r = '0;
			if ($urandom_range(0, 19) == 0)
				c = '0;
			case ($urandom_range(0, 3))
				0: write_reg(REG_ROW_COUNT, r);
				1: write_reg(REG_COL_COUNT, c);
				default: begin
					write_reg(REG_ROW_COUNT, r);
					write_reg(REG_COL_COUNT, c);
				end
			endcase
			cells = clamp_dim(rows_reg, ROW_LIMIT) * clamp_dim(cols_reg, COL_LIMIT);
			grids = $urandom_range(1, 4);
			cut   = 1'b0;
			for (int g = 0; g < grids && !cut && items_sent < goal; g++) begin
				pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(40, 100);
				if (cells > 1 && $urandom_range(0, 9) == 0) begin
					// abandon the grid part way; the next register write restarts the scan
					send_random_cells($urandom_range(1, cells - 1), pct);
					cut = 1'b1;
				end else begin
					send_random_cells(cells, pct);
				end
			end
		end
		drain_results();
	endtask

	always @(negedge clk)
		result_ch.ready <= no_idle || ($urandom_range(0, 99) >= 9);

	always @(posedge clk) begin : check_square
		square_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_squares.size() == 0) begin
				errors++;
				$display("%0t: unexpected result size %0d row %0d col %0d", $time,
					result_ch.square_size, result_ch.top_row, result_ch.left_col);
			end else begin
				want = pending_squares.pop_front();
				if (result_ch.square_size !== want.square_size) begin
					errors++;
					$display("%0t: square_size expected %0d actual %0d", $time,
						want.square_size, result_ch.square_size);
				end
				if (result_ch.top_row !== want.top_row) begin
					errors++;
					$display("%0t: top_row expected %0d actual %0d", $time,
						want.top_row, result_ch.top_row);
				end
				if (result_ch.left_col !== want.left_col) begin
					errors++;
					$display("%0t: left_col expected %0d actual %0d", $time,
						want.left_col, result_ch.left_col);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cell_ch.valid    = 1'b0;
		cell_ch.is_empty = 1'b0;
		result_ch.ready  = 1'b0;
		errors           = 0;
		items_sent       = 0;
		no_idle          = 1'b0;
		rows_reg         = 11'd1;
		cols_reg         = 11'd1;
		foreach (line_sizes[i])
			line_sizes[i] = 0;
		clear_scan();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed_grids();
		run_count_limits();
		run_scan_restart();
		run_random_grids();

		drain_results();
		if (errors == 0 && pending_squares.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
